### hw/rtl/tcfp_pkg.sv
package tcfp_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned IdentWidth = 32;
  localparam int unsigned LenWidth   = 4;
  localparam int unsigned DataWidth  = 64;
  localparam int unsigned PosWidth   = 6;

  localparam logic [CharWidth-1:0] KindExtData   = 8'h58;  // 'X'
  localparam logic [CharWidth-1:0] KindExtRemote = 8'h52;  // 'R'
  localparam logic [CharWidth-1:0] KindStdData   = 8'h53;  // 'S'
  localparam logic [CharWidth-1:0] KindStdRemote = 8'h72;  // 'r'

  localparam logic [PosWidth-1:0] ExtLenPos  = 6'd15;
  localparam logic [PosWidth-1:0] StdLenPos  = 6'd8;
  localparam logic [PosWidth-1:0] ExtDataPos = 6'd19;
  localparam logic [PosWidth-1:0] StdDataPos = 6'd12;

  typedef struct packed {
    logic                 line_start;
    logic [CharWidth-1:0] text_char;
  } tcfp_item_t;

  typedef struct packed {
    logic [DataWidth-1:0]  frame_data;
    logic [LenWidth-1:0]   frame_length;
    logic [IdentWidth-1:0] frame_ident;
    logic                  is_remote;
    logic                  is_extended;
    logic                  parse_error;
  } tcfp_result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] nibble;
  } tcfp_ident_slot_t;

  function automatic logic [3:0] hex_value(input logic [CharWidth-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

  function automatic tcfp_ident_slot_t ident_slot(input logic ext, input logic [PosWidth-1:0] p);
    tcfp_ident_slot_t s;
    s = '{hit: 1'b0, nibble: 3'd0};
    if (ext) begin
      unique case (p)
        6'd2:    s = '{hit: 1'b1, nibble: 3'd7};
        6'd3:    s = '{hit: 1'b1, nibble: 3'd6};
        6'd5:    s = '{hit: 1'b1, nibble: 3'd5};
        6'd6:    s = '{hit: 1'b1, nibble: 3'd4};
        6'd7:    s = '{hit: 1'b1, nibble: 3'd3};
        6'd9:    s = '{hit: 1'b1, nibble: 3'd2};
        6'd10:   s = '{hit: 1'b1, nibble: 3'd1};
        6'd11:   s = '{hit: 1'b1, nibble: 3'd0};
        default: s = '{hit: 1'b0, nibble: 3'd0};
      endcase
    end else begin
      unique case (p)
        6'd2:    s = '{hit: 1'b1, nibble: 3'd2};
        6'd3:    s = '{hit: 1'b1, nibble: 3'd1};
        6'd4:    s = '{hit: 1'b1, nibble: 3'd0};
        default: s = '{hit: 1'b0, nibble: 3'd0};
      endcase
    end
    return s;
  endfunction

endpackage

### hw/rtl/tcfp_parse.sv
module tcfp_parse #(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  tcfp_pkg::tcfp_item_t  item_i,
  output logic                  emit_o,
  output tcfp_pkg::tcfp_result_t result_o
);
  import tcfp_pkg::*;

  localparam int unsigned StoreWidth = 8 * MAX_DATA_BYTES;
  localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MAX_DATA_BYTES);

  logic [PosWidth-1:0]   pos_q, pos_d;
  logic                  active_q, active_d;
  logic                  ext_q, ext_d;
  logic                  rem_q, rem_d;
  logic [IdentWidth-1:0] ident_q, ident_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [StoreWidth-1:0] data_q, data_d;
  logic [1:0]            phase_q, phase_d;
  logic [3:0]            byte_q, byte_d;

  logic [PosWidth-1:0] pos_n;
  logic [PosWidth-1:0] len_pos;
  logic [PosWidth-1:0] data_pos;
  logic [3:0]          hex;
  logic                emit;
  logic                err;
  tcfp_ident_slot_t    slot;

  always_comb begin
    pos_n    = pos_q + PosWidth'(1);
    len_pos  = ext_q ? ExtLenPos : StdLenPos;
    data_pos = ext_q ? ExtDataPos : StdDataPos;
    hex      = hex_value(item_i.text_char);
    slot     = ident_slot(ext_q, pos_n);

    pos_d    = pos_q;
    active_d = active_q;
    ext_d    = ext_q;
    rem_d    = rem_q;
    ident_d  = ident_q;
    len_d    = len_q;
    data_d   = data_q;
    phase_d  = phase_q;
    byte_d   = byte_q;
    emit     = 1'b0;
    err      = 1'b0;

    if (item_i.line_start) begin
      pos_d    = '0;
      ident_d  = '0;
      len_d    = '0;
      data_d   = '0;
      active_d = 1'b1;
      if (item_i.text_char == KindExtData || item_i.text_char == KindExtRemote) begin
        ext_d = 1'b1;
        rem_d = (item_i.text_char == KindExtRemote);
      end else if (item_i.text_char == KindStdData || item_i.text_char == KindStdRemote) begin
        ext_d = 1'b0;
        rem_d = (item_i.text_char == KindStdRemote);
      end else begin
        ext_d    = 1'b0;
        rem_d    = 1'b0;
        active_d = 1'b0;
        emit     = 1'b1;
        err      = 1'b1;
      end
    end else if (active_q) begin
      pos_d = pos_n;
      if (pos_n < len_pos) begin
        if (slot.hit) begin
          ident_d = ident_q | (IdentWidth'(hex) << {slot.nibble, 2'b00});
        end
      end else if (pos_n == len_pos) begin
        if (hex > MaxLen) begin
          len_d    = '0;
          active_d = 1'b0;
          emit     = 1'b1;
          err      = 1'b1;
        end else begin
          len_d = hex;
          if (hex == 4'd0) begin
            active_d = 1'b0;
            emit     = 1'b1;
          end
        end
      end else if (pos_n >= data_pos) begin
        if (pos_n == data_pos) begin
          phase_d = 2'd0;
          byte_d  = 4'd0;
        end else if (phase_q == 2'd2) begin
          phase_d = 2'd0;
          byte_d  = byte_q + 4'd1;
        end else begin
          phase_d = phase_q + 2'd1;
          byte_d  = byte_q;
        end
        if (byte_d < len_q) begin
          for (int unsigned b = 0; b < MAX_DATA_BYTES; b++) begin
            if (byte_d == 4'(b)) begin
              if (phase_d == 2'd0) begin
                data_d[8*b+4 +: 4] = data_q[8*b+4 +: 4] | hex;
              end else if (phase_d == 2'd1) begin
                data_d[8*b +: 4] = data_q[8*b +: 4] | hex;
              end
            end
          end
          if (phase_d == 2'd1 && (byte_d + 4'd1) == len_q) begin
            active_d = 1'b0;
            emit     = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    emit_o                = emit;
    result_o.parse_error  = err;
    result_o.is_extended  = !err && ext_d;
    result_o.is_remote    = !err && rem_d;
    result_o.frame_ident  = err ? '0 : ident_d;
    result_o.frame_length = err ? '0 : len_d;
    result_o.frame_data   = err ? '0 : DataWidth'(data_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      ext_q    <= 1'b0;
      rem_q    <= 1'b0;
      ident_q  <= '0;
      len_q    <= '0;
      data_q   <= '0;
      phase_q  <= '0;
      byte_q   <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      active_q <= active_d;
      ext_q    <= ext_d;
      rem_q    <= rem_d;
      ident_q  <= ident_d;
      len_q    <= len_d;
      data_q   <= data_d;
      phase_q  <= phase_d;
      byte_q   <= byte_d;
    end
  end

endmodule

### hw/rtl/tcfp_out_reg.sv
module tcfp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  tcfp_pkg::tcfp_result_t result_i,
  input  logic                   ready_i,
  output logic                   full_o,
  output tcfp_pkg::tcfp_result_t result_o
);
  import tcfp_pkg::*;

  logic         valid_q, valid_d;
  tcfp_result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign full_o   = valid_q;
  assign result_o = result_q;

endmodule

### hw/rtl/text_to_can_frame_parser_core.sv
// Channel   Direction  tdata                                    tuser
// s_axis    in         [7:0] text_char                          [0] line_start
// m_axis    out        [31:0] frame_ident, [35:32] frame_length, [0] parse_error,
//                      [99:36] frame_data, [103:100] zero        [1] is_extended, [2] is_remote
//
// One character is taken per cycle while s_axis_tready is high; each passes an input register
// and the parser logic, and its result is loaded into the output register when the parser
// fires on that character, and leaves from there on m_axis.
// Reset clears the line state and the valid flags of both registers.
// A full output register that is not taken stalls the input register, and s_axis_tready
// drops only when that register is also full.
module text_to_can_frame_parser_core #(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] text_char
  input  logic [0:0]   s_axis_tuser,   // [0] line_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [31:0] frame_ident, [35:32] frame_length,
                                       // [99:36] frame_data, [103:100] zero
  output logic [2:0]   m_axis_tuser    // [0] parse_error, [1] is_extended, [2] is_remote
);
  import tcfp_pkg::*;

  logic         in_valid_q, in_valid_d;
  tcfp_item_t   in_item_q;
  logic         fire;
  logic         emit;
  logic         out_full;
  tcfp_result_t result;
  tcfp_result_t out_result;

  assign fire          = in_valid_q && (!out_full || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.text_char  <= s_axis_tdata;
      in_item_q.line_start <= s_axis_tuser[0];
    end
  end

  tcfp_parse #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_item_q),
    .emit_o  (emit),
    .result_o(result)
  );

  tcfp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && emit),
    .result_i(result),
    .ready_i (m_axis_tready),
    .full_o  (out_full),
    .result_o(out_result)
  );

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {4'd0, out_result.frame_data, out_result.frame_length,
                          out_result.frame_ident};
  assign m_axis_tuser  = {out_result.is_remote, out_result.is_extended,
                          out_result.parse_error};

endmodule

### bench/text_to_can_frame_parser_core_test.sv
module text_to_can_frame_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcfp_pkg::*;

  localparam int MaxBytes   = 8;
  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic [0:0]   s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  tcfp_item_t   chars_waiting[$];
  tcfp_result_t frames_due[$];
  tcfp_item_t   next_char;
  tcfp_result_t want;
  tcfp_result_t seen;

  logic         calm = 1'b0;
  logic         hold_now = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           errors = 0;
  int           cycles = 0;

  logic [5:0]   line_pos = '0;
  logic         in_line = 1'b0;
  logic         kind_ext = 1'b0;
  logic         kind_rtr = 1'b0;
  logic [31:0]  ident_acc = '0;
  logic [3:0]   len_acc = '0;
  logic [63:0]  data_acc = '0;

  text_to_can_frame_parser_core #(
    .MAX_DATA_BYTES(MaxBytes)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Nibble index of the identifier digit at a line position, or -1 for none.
  function automatic int ident_nibble(input logic ext, input int pos);
    if (ext) begin
      case (pos)
        2: return 7;
        3: return 6;
        5: return 5;
        6: return 4;
        7: return 3;
        9: return 2;
        10: return 1;
        11: return 0;
        default: return -1;
      endcase
    end
    case (pos)
      2: return 2;
      3: return 1;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic finish_line(input logic failed);
    tcfp_result_t r;
    r = '0;
    r.parse_error = failed;
    if (!failed) begin
      r.is_extended  = kind_ext;
      r.is_remote    = kind_rtr;
      r.frame_ident  = ident_acc;
      r.frame_length = len_acc;
      r.frame_data   = data_acc;
    end
    frames_due.push_back(r);
    in_line = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic first);
    logic [3:0] h;
    int len_at;
    int data_at;
    int nib;
    int off;
    int k;
    if (first) begin
      line_pos  = '0;
      ident_acc = '0;
      len_acc   = '0;
      data_acc  = '0;
      kind_ext  = (c == KindExtData) || (c == KindExtRemote);
      kind_rtr  = (c == KindExtRemote) || (c == KindStdRemote);
      if (kind_ext || c == KindStdData || c == KindStdRemote) begin
        in_line = 1'b1;
      end else begin
        kind_ext = 1'b0;
        kind_rtr = 1'b0;
        finish_line(1'b1);
      end
    end else if (in_line) begin
      line_pos = line_pos + 6'd1;
      h = nibble_of(c);
      len_at  = kind_ext ? int'(ExtLenPos) : int'(StdLenPos);
      data_at = kind_ext ? int'(ExtDataPos) : int'(StdDataPos);
      if (int'(line_pos) < len_at) begin
        nib = ident_nibble(kind_ext, int'(line_pos));
        if (nib >= 0) ident_acc = ident_acc | (32'(h) << (4 * nib));
      end else if (int'(line_pos) == len_at) begin
        if (int'(h) > MaxBytes) begin
          len_acc = '0;
          finish_line(1'b1);
        end else begin
          len_acc = h;
          if (h == 4'd0) finish_line(1'b0);
        end
      end else if (int'(line_pos) >= data_at) begin
        off = int'(line_pos) - data_at;
        k = off / 3;
        if (k < int'(len_acc) && k < 8) begin
          if (off % 3 == 0) begin
            data_acc = data_acc | (64'(h) << (8 * k + 4));
          end else if (off % 3 == 1) begin
            data_acc = data_acc | (64'(h) << (8 * k));
            if (k + 1 == int'(len_acc)) finish_line(1'b0);
          end
        end
      end
    end
  endtask

  // Queues one text line; cut_at > 0 stops it after that many characters.
  task automatic queue_line(input logic [7:0] kind, input logic [31:0] ident,
                            input logic [7:0] len_ch, input logic [63:0] data,
                            input int junk_pct, input int cut_at, inout int counted);
    logic ext;
    logic digit;
    logic [7:0] ch;
    int len_at;
    int data_at;
    int n;
    int last;
    int nib;
    int off;
    chars_waiting.push_back('{line_start: 1'b1, text_char: kind});
    counted++;
    if (!(kind == KindExtData || kind == KindExtRemote || kind == KindStdData ||
          kind == KindStdRemote)) return;
    ext = (kind == KindExtData) || (kind == KindExtRemote);
    len_at  = ext ? int'(ExtLenPos) : int'(StdLenPos);
    data_at = ext ? int'(ExtDataPos) : int'(StdDataPos);
    n = int'(nibble_of(len_ch));
    last = (n > MaxBytes || n == 0) ? len_at : data_at + 3 * (n - 1) + 1;
    if (cut_at > 0 && cut_at - 1 < last) last = cut_at - 1;
    for (int p = 1; p <= last; p++) begin
      nib = ident_nibble(ext, p);
      off = p - data_at;
      digit = 1'b1;
      if (nib >= 0) begin
        ch = hex_char(ident[4 * nib +: 4]);
      end else if (p == len_at) begin
        ch = len_ch;
        digit = 1'b0;
      end else if (p > len_at && off >= 0 && off % 3 != 2) begin
        ch = hex_char(off % 3 == 0 ? data[8 * (off / 3) + 4 +: 4] : data[8 * (off / 3) +: 4]);
      end else begin
        ch = $urandom_range(1) ? 8'h20 : 8'($urandom_range(255));
        digit = 1'b0;
      end
      if (digit && $urandom_range(99) < junk_pct) ch = 8'($urandom_range(255));
      chars_waiting.push_back('{line_start: 1'b0, text_char: ch});
      counted++;
    end
  endtask

  task automatic idle_noise(input int n);
    for (int i = 0; i < n; i++) begin
      chars_waiting.push_back('{line_start: 1'b0, text_char: 8'($urandom_range(255))});
    end
  endtask

  task automatic random_line(inout int counted);
    int r;
    int cut;
    logic [7:0] kind;
    logic [7:0] len_ch;
    r = $urandom_range(99);
    if (r < 22) kind = KindExtData;
    else if (r < 44) kind = KindExtRemote;
    else if (r < 66) kind = KindStdData;
    else if (r < 88) kind = KindStdRemote;
    else kind = 8'($urandom_range(255));
    len_ch = ($urandom_range(99) < 85) ? hex_char(4'($urandom_range(MaxBytes)))
                                       : 8'($urandom_range(255));
    cut = ($urandom_range(99) < 8) ? $urandom_range(1, 20) : 0;
    queue_line(kind, $urandom, len_ch, {$urandom, $urandom},
               ($urandom_range(9) == 0) ? 20 : 0, cut, counted);
    if (cut == 0 && $urandom_range(4) == 0) idle_noise($urandom_range(1, 4));
  endtask

  task automatic wait_idle();
    while (chars_waiting.size() != 0 || s_axis_tvalid || frames_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (chars_waiting.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        next_char = chars_waiting.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_char.text_char;
        s_axis_tuser  <= next_char.line_start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_now && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || $urandom_range(99) >= 36;
    end
  end

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) parse_char(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.parse_error  = m_axis_tuser[0];
        seen.is_extended  = m_axis_tuser[1];
        seen.is_remote    = m_axis_tuser[2];
        seen.frame_ident  = m_axis_tdata[31:0];
        seen.frame_length = m_axis_tdata[35:32];
        seen.frame_data   = m_axis_tdata[99:36];
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual %h %h", $time,
                   m_axis_tuser, m_axis_tdata);
        end else begin
          want = frames_due.pop_front();
          check_field("parse_error", 64'(want.parse_error), 64'(seen.parse_error));
          check_field("is_extended", 64'(want.is_extended), 64'(seen.is_extended));
          check_field("is_remote", 64'(want.is_remote), 64'(seen.is_remote));
          check_field("frame_ident", 64'(want.frame_ident), 64'(seen.frame_ident));
          check_field("frame_length", 64'(want.frame_length), 64'(seen.frame_length));
          check_field("frame_data", want.frame_data, seen.frame_data);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int line_chars;
    int lines;
    line_chars = 0;
    lines = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes of kind, identifier and length, then the error and odd cases.
    queue_line(KindStdData, 32'h000, 8'h30, 64'h0, 0, 0, line_chars);
    queue_line(KindStdRemote, 32'hFFF, 8'h38, '1, 0, 0, line_chars);
    queue_line(KindExtData, '1, 8'h38, '1, 0, 0, line_chars);
    queue_line(KindExtRemote, 32'h0, 8'h31, 64'h0, 0, 0, line_chars);
    queue_line(KindExtData, 32'h1234_5678, 8'h39, 64'h0, 0, 0, line_chars);
    queue_line(KindStdData, 32'hABC, 8'h66, 64'h0, 0, 0, line_chars);
    queue_line(8'h00, 32'h0, 8'h30, 64'h0, 0, 0, line_chars);
    idle_noise(3);
    queue_line(8'hFF, 32'h0, 8'h30, 64'h0, 0, 0, line_chars);
    queue_line(8'h78, 32'h0, 8'h30, 64'h0, 0, 0, line_chars);
    queue_line(KindStdData, 32'h5A5, 8'h34, 64'h0123_4567_89AB_CDEF, 100, 0, line_chars);
    queue_line(KindExtData, 32'h0ACE_F00D, 8'h47, 64'h0, 0, 0, line_chars);
    queue_line(KindExtData, 32'h1FFF_FFFF, 8'h38, 64'h1122_3344_5566_7788, 0, 12,
               line_chars);
    queue_line(KindStdRemote, 32'h123, 8'h32, 64'hBEEF, 0, 0, line_chars);
    idle_noise(4);
    wait_idle();

    calm = 1'b1;
    for (int i = 0; i < 12; i++) begin
      random_line(line_chars);
      lines++;
    end
    wait_idle();
    calm = 1'b0;

    while (line_chars < 1250 || lines < 70) begin
      random_line(line_chars);
      lines++;
    end
    hold_now = 1'b1;
    wait_idle();
    repeat (8) @(negedge clk_i);

    if (errors == 0 && frames_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
